// ===== rtl/bve_pkg.sv =====
// Shared widths, constants and types of the barometric velocity estimator.
package bve_pkg;

	localparam int DATA_W    = 32;
	localparam int AVG_DEPTH = 10;
	localparam int AVG_CNT_W = $clog2(AVG_DEPTH);
	localparam int SUM_W     = DATA_W + AVG_CNT_W;

	localparam int SPS_W = 10;
	localparam logic [SPS_W-1:0] SPS_RESET = 10'd50;

	localparam int DIFF_W = DATA_W + 1;
	localparam int RATE_W = DIFF_W + SPS_W + 1;
	localparam int R4F_W  = RATE_W + 2;
	localparam int R4_W   = 35;
	localparam int ACC_W  = R4_W + 1;

	localparam int DIV5_IN_W = 34;
	localparam int DIV5_K    = 36;
	localparam int DIV5_Q_W  = DATA_W - 1;
	localparam logic [DIV5_IN_W-1:0] DIV5_MUL = 34'd13743895348;
	localparam logic [ACC_W-1:0]     SAT_MAG  = 36'd10737418240;

	localparam int MAG_W     = SUM_W;
	localparam int AVG_K     = SUM_W + AVG_CNT_W;
	localparam int AVG_MUL_W = AVG_K - AVG_CNT_W + 2;
	localparam logic [63:0] AVG_MUL_FULL =
		((64'd1 << AVG_K) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
	localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_FULL[AVG_MUL_W-1:0];
	localparam int LO_W   = 18;
	localparam int HI_W   = MAG_W - LO_W;
	localparam int PLO_W  = LO_W + AVG_MUL_W;
	localparam int PHI_W  = HI_W + AVG_MUL_W;
	localparam int PROD_W = MAG_W + AVG_MUL_W;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef struct packed {
		logic  shift;
		word_t vel;
	} ring_push_t;

endpackage

// ===== rtl/bve_cell.sv =====
// One ring cell: holds a velocity word and passes it on at each shift.
module bve_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  bve_pkg::word_t d,
	output bve_pkg::word_t q
);
	import bve_pkg::*;

	word_t val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

// ===== rtl/bve_ring.sv =====
// Chain of velocity cells with the running sum over the chain.
module bve_ring (
	input  logic               clk,
	input  logic               arst_n,
	input  bve_pkg::ring_push_t push,
	output bve_pkg::sum_t      sum
);
	import bve_pkg::*;

	word_t cell_q [AVG_DEPTH];
	sum_t  sum_q;

	for (genvar i = 0; i < AVG_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			bve_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (push.shift),
				.d     (push.vel),
				.q     (cell_q[i])
			);
		end else begin : g_body
			bve_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (push.shift),
				.d     (cell_q[i-1]),
				.q     (cell_q[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (push.shift) begin
			sum_q <= sum_q
				- {{(SUM_W-DATA_W){cell_q[AVG_DEPTH-1][DATA_W-1]}}, cell_q[AVG_DEPTH-1]}
				+ {{(SUM_W-DATA_W){push.vel[DATA_W-1]}}, push.vel};
		end
	end

	assign sum = sum_q;

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(push.shift) |-> $stable(sum_q))
		else $error("ring sum moved without a shift");

endmodule

// ===== rtl/baro_velocity_estimator.sv =====
// Top level of the barometric velocity estimator.
// Takes one altitude word per cycle while in_stall is low and returns one result word per
// altitude, in order, through registered stages s1 to s8. The smoothed velocity is formed
// combinationally (add, divide by five, saturate), which sets the one-word-per-cycle rate;
// the ten-deep velocity history is a chain of cells that shifts once per word while a
// running sum tracks it, and the mean is formed from that sum by a pipelined reciprocal
// multiply. The pipeline advances whenever its output register is empty or being taken.
module baro_velocity_estimator (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [bve_pkg::SPS_W-1:0] cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  bve_pkg::word_t           altitude_mm,
	output logic                     out_valid,
	input  logic                     out_stall,
	output bve_pkg::word_t           altitude_out_mm,
	output bve_pkg::word_t           velocity_mm_s,
	output bve_pkg::word_t           avg_velocity_mm_s
);
	import bve_pkg::*;

	logic adv;
	logic in_acc;

	logic [SPS_W-1:0] sps_q;
	word_t            prev_alt_q;
	word_t            vel_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	word_t alt_s1, alt_s2, alt_s3, alt_s4, alt_s5, alt_s6, alt_s7, alt_s8;
	word_t vel_s3, vel_s4, vel_s5, vel_s6, vel_s7, vel_s8;

	logic signed [DIFF_W-1:0] diff_s1;
	logic                     nz_s1;
	logic signed [R4_W-1:0]   r4c_s2;
	logic                     nz_s2;

	logic [MAG_W-1:0]  mag_s5;
	logic              neg_s5, neg_s6, neg_s7;
	logic [PLO_W-1:0]  plo_s6;
	logic [PHI_W-1:0]  phi_s6;
	logic [DATA_W-1:0] q_s7;
	word_t             avg_s8;

	logic signed [DIFF_W-1:0] diff;
	logic signed [RATE_W-1:0] rate;
	logic signed [R4F_W-1:0]  r4;
	logic signed [R4_W-1:0]   r4c;
	logic signed [ACC_W-1:0]  acc;
	logic [ACC_W-1:0]         acc_mag;
	logic [2*DIV5_IN_W-1:0]   div5_prod;
	logic [DIV5_Q_W-1:0]      q5;
	word_t                    vel_new;
	word_t                    vel_nxt;
	ring_push_t               push;
	sum_t                     ring_sum;
	logic [MAG_W-1:0]         sum_mag;
	logic [PLO_W-1:0]         plo;
	logic [PHI_W-1:0]         phi;
	logic [PROD_W-1:0]        prod;

	assign adv      = !vld_s8 || !out_stall;
	assign in_stall = !adv;
	assign in_acc   = in_valid && adv;

	// rate path, outside the velocity loop
	assign diff = {altitude_mm[DATA_W-1], altitude_mm} - {prev_alt_q[DATA_W-1], prev_alt_q};
	assign rate = diff_s1 * $signed({1'b0, sps_q});
	assign r4   = {rate, 2'b00};

	always_comb begin
		if (r4[R4F_W-1:R4_W-1] == {(R4F_W-R4_W+1){r4[R4F_W-1]}}) begin
			r4c = r4[R4_W-1:0];
		end else if (r4[R4F_W-1]) begin
			r4c = {1'b1, {(R4_W-1){1'b0}}};
		end else begin
			r4c = {1'b0, {(R4_W-1){1'b1}}};
		end
	end

	// velocity loop: (v + 4*rate) / 5, toward zero, saturated
	assign acc       = {r4c_s2[R4_W-1], r4c_s2}
		+ {{(ACC_W-DATA_W){vel_q[DATA_W-1]}}, vel_q};
	assign acc_mag   = acc[ACC_W-1] ? -acc : acc;
	assign div5_prod = acc_mag[DIV5_IN_W-1:0] * DIV5_MUL;
	assign q5        = div5_prod[DIV5_K +: DIV5_Q_W];

	always_comb begin
		if (acc_mag >= SAT_MAG) begin
			vel_new = acc[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else if (acc[ACC_W-1]) begin
			vel_new = -{1'b0, q5};
		end else begin
			vel_new = {1'b0, q5};
		end
	end

	assign vel_nxt = nz_s2 ? vel_new : vel_q;

	// history chain and running sum
	assign push.shift = adv && vld_s3;
	assign push.vel   = vel_s3;

	bve_ring u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.sum   (ring_sum)
	);

	// mean: magnitude, split reciprocal multiply, recombine, sign
	assign sum_mag = ring_sum[SUM_W-1] ? -ring_sum : ring_sum;
	assign plo     = {{AVG_MUL_W{1'b0}}, mag_s5[LO_W-1:0]} * {{LO_W{1'b0}}, AVG_MUL};
	assign phi     = {{AVG_MUL_W{1'b0}}, mag_s5[MAG_W-1:LO_W]} * {{HI_W{1'b0}}, AVG_MUL};
	assign prod    = {phi_s6, {LO_W{1'b0}}} + {{(PROD_W-PLO_W){1'b0}}, plo_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_q      <= SPS_RESET;
			prev_alt_q <= '0;
			vel_q      <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			vld_s6     <= 1'b0;
			vld_s7     <= 1'b0;
			vld_s8     <= 1'b0;
		end else begin
			if (cfg_we) begin
				sps_q <= cfg_wdata;
			end
			if (in_acc) begin
				prev_alt_q <= altitude_mm;
			end
			if (adv && vld_s2) begin
				vel_q <= vel_nxt;
			end
			if (adv) begin
				vld_s1 <= in_valid;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3;
				vld_s5 <= vld_s4;
				vld_s6 <= vld_s5;
				vld_s7 <= vld_s6;
				vld_s8 <= vld_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			alt_s1  <= altitude_mm;
			diff_s1 <= diff;
			nz_s1   <= (prev_alt_q != '0);

			alt_s2  <= alt_s1;
			r4c_s2  <= r4c;
			nz_s2   <= nz_s1;

			alt_s3  <= alt_s2;
			vel_s3  <= vel_nxt;

			alt_s4  <= alt_s3;
			vel_s4  <= vel_s3;

			alt_s5  <= alt_s4;
			vel_s5  <= vel_s4;
			mag_s5  <= sum_mag;
			neg_s5  <= ring_sum[SUM_W-1];

			alt_s6  <= alt_s5;
			vel_s6  <= vel_s5;
			plo_s6  <= plo;
			phi_s6  <= phi;
			neg_s6  <= neg_s5;

			alt_s7  <= alt_s6;
			vel_s7  <= vel_s6;
			q_s7    <= prod[AVG_K +: DATA_W];
			neg_s7  <= neg_s6;

			alt_s8  <= alt_s7;
			vel_s8  <= vel_s7;
			avg_s8  <= neg_s7 ? -q_s7 : q_s7;
		end
	end

	assign out_valid         = vld_s8;
	assign altitude_out_mm   = alt_s8;
	assign velocity_mm_s     = vel_s8;
	assign avg_velocity_mm_s = avg_s8;

	a_vel_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(vel_q) |-> $past(adv && vld_s2 && nz_s2))
		else $error("velocity changed without a word in the smoother");

	a_prev_alt: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> prev_alt_q == $past(altitude_mm))
		else $error("previous altitude not taken from accepted word");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_s7 && adv))
		else $error("output valid without a word in the last stage");

endmodule
